// File: rtl/utf8de_pkg.sv
`timescale 1ns / 1ps
package utf8de_pkg;

  localparam int unsigned CP_W       = 21;
  localparam int unsigned LEN_W      = 3;
  localparam int unsigned OFS_W      = 32;
  localparam int unsigned FIFO_DEPTH = 4;

  localparam logic [CP_W-1:0] REPLACEMENT_CP = 21'h00FFFD;

  typedef struct packed {
    logic [2:0]       rep_cnt;   // leading U+FFFD results
    logic             has_tail;  // one decoded result after them
    logic [CP_W-1:0]  tail_cp;
    logic [LEN_W-1:0] tail_len;
    logic             eot;
  } job_t;

  function automatic logic in_emoji_set(input logic [CP_W-1:0] cp);
    logic hit;
    hit = 1'b0;
    if (cp >= 21'h1F300 && cp <= 21'h1FAFF) hit = 1'b1;
    if (cp >= 21'h1F000 && cp <= 21'h1F0FF) hit = 1'b1;
    if (cp >= 21'h02600 && cp <= 21'h027BF) hit = 1'b1;
    if (cp >= 21'h1F1E6 && cp <= 21'h1F1FF) hit = 1'b1;
    if (cp == 21'h0FE0F || cp == 21'h0200D) hit = 1'b1;
    return hit;
  endfunction

endpackage

// File: rtl/utf8de_front.sv
`timescale 1ns / 1ps
module utf8de_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [7:0]          byte_i,
  input  logic                eot_i,
  output logic                push_o,
  output utf8de_pkg::job_t    job_o
);
  import utf8de_pkg::*;

  logic [CP_W-1:0]  partial_q, partial_d;
  logic [2:0]       seq_len_q, seq_len_d;
  logic [2:0]       taken_q, taken_d;

  logic             is_cont;
  logic [CP_W-1:0]  cont_val;
  logic [2:0]       taken_inc;
  job_t             job;

  always_comb begin
    is_cont   = (byte_i[7:6] == 2'b10);
    cont_val  = {partial_q[CP_W-7:0], byte_i[5:0]};
    taken_inc = taken_q + 3'd1;

    job          = '0;
    job.eot      = eot_i;
    job.tail_len = 3'd1;
    partial_d    = partial_q;
    seq_len_d    = seq_len_q;
    taken_d      = taken_q;

    if (seq_len_q != 3'd0 && is_cont) begin
      if (taken_inc >= seq_len_q) begin
        job.has_tail = 1'b1;
        job.tail_cp  = cont_val;
        job.tail_len = seq_len_q;
        partial_d    = '0;
        seq_len_d    = 3'd0;
        taken_d      = 3'd0;
      end else begin
        partial_d = cont_val;
        taken_d   = taken_inc;
        if (eot_i) begin
          job.rep_cnt = taken_inc;
        end
      end
    end else begin
      // flush any pending bytes, then treat this byte as a lead
      job.rep_cnt = (seq_len_q != 3'd0) ? taken_q : 3'd0;
      partial_d   = '0;
      seq_len_d   = 3'd0;
      taken_d     = 3'd0;
      if (!byte_i[7]) begin
        job.has_tail = 1'b1;
        job.tail_cp  = {13'd0, byte_i};
      end else if (byte_i[7:5] == 3'b110) begin
        seq_len_d = 3'd2;
        taken_d   = 3'd1;
        partial_d = {16'd0, byte_i[4:0]};
      end else if (byte_i[7:4] == 4'b1110) begin
        seq_len_d = 3'd3;
        taken_d   = 3'd1;
        partial_d = {17'd0, byte_i[3:0]};
      end else if (byte_i[7:3] == 5'b11110) begin
        seq_len_d = 3'd4;
        taken_d   = 3'd1;
        partial_d = {18'd0, byte_i[2:0]};
      end else begin
        job.rep_cnt = job.rep_cnt + 3'd1;
      end
      if (eot_i && seq_len_d != 3'd0) begin
        job.rep_cnt = job.rep_cnt + 3'd1;
      end
    end

    if (eot_i) begin
      partial_d = '0;
      seq_len_d = 3'd0;
      taken_d   = 3'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      partial_q <= '0;
      seq_len_q <= 3'd0;
      taken_q   <= 3'd0;
    end else if (accept_i) begin
      partial_q <= partial_d;
      seq_len_q <= seq_len_d;
      taken_q   <= taken_d;
    end
  end

  assign job_o  = job;
  assign push_o = accept_i && (job.rep_cnt != 3'd0 || job.has_tail || eot_i);

endmodule

// File: rtl/utf8de_fifo.sv
`timescale 1ns / 1ps
module utf8de_fifo #(
  parameter int unsigned Depth = utf8de_pkg::FIFO_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  utf8de_pkg::job_t    job_i,
  input  logic                pop_i,
  output logic                full_o,
  output logic                valid_o,
  output utf8de_pkg::job_t    job_o
);
  import utf8de_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign job_o   = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

// File: rtl/utf8de_back.sv
`timescale 1ns / 1ps
module utf8de_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          emoji_font_i,
  input  logic                          head_valid_i,
  input  utf8de_pkg::job_t              head_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [utf8de_pkg::CP_W-1:0]   code_point_o,
  output logic [utf8de_pkg::LEN_W-1:0]  byte_length_o,
  output logic [utf8de_pkg::OFS_W-1:0]  byte_offset_o,
  output logic                          emoji_o,
  output logic                          run_start_o,
  output logic                          last_o
);
  import utf8de_pkg::*;

  logic [2:0]       idx_q, idx_d;
  logic [OFS_W-1:0] pos_q, pos_d;
  logic             prev_emo_q, prev_emo_d;
  logic             seen_q, seen_d;
  logic             valid_q, valid_d;

  logic [CP_W-1:0]  cp_q, cp_sel;
  logic [LEN_W-1:0] len_q, len_sel;
  logic [OFS_W-1:0] ofs_q;
  logic             emo_q, run_q, last_q;

  logic [2:0] total;
  logic       can_emit, fire, emit, last_item, emo;

  always_comb begin
    total     = head_i.rep_cnt + {2'b00, head_i.has_tail};
    can_emit  = !valid_q || out_ready_i;
    fire      = head_valid_i && can_emit;
    emit      = fire && (total != 3'd0);
    last_item = (idx_q == total - 3'd1);
    if (head_i.has_tail && idx_q == head_i.rep_cnt) begin
      cp_sel  = head_i.tail_cp;
      len_sel = head_i.tail_len;
    end else begin
      cp_sel  = REPLACEMENT_CP;
      len_sel = 3'd1;
    end
    emo = emoji_font_i && in_emoji_set(cp_sel);

    pop_o      = fire && (total == 3'd0 || last_item);
    valid_d    = can_emit ? emit : valid_q;
    idx_d      = idx_q;
    pos_d      = pos_q;
    prev_emo_d = prev_emo_q;
    seen_d     = seen_q;

    if (emit) begin
      idx_d      = last_item ? 3'd0 : idx_q + 3'd1;
      pos_d      = pos_q + {29'd0, len_sel};
      prev_emo_d = emo;
      seen_d     = 1'b1;
    end
    if (pop_o && head_i.eot) begin
      pos_d      = '0;
      prev_emo_d = 1'b0;
      seen_d     = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q      <= 3'd0;
      pos_q      <= '0;
      prev_emo_q <= 1'b0;
      seen_q     <= 1'b0;
      valid_q    <= 1'b0;
    end else begin
      idx_q      <= idx_d;
      pos_q      <= pos_d;
      prev_emo_q <= prev_emo_d;
      seen_q     <= seen_d;
      valid_q    <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      cp_q   <= cp_sel;
      len_q  <= len_sel;
      ofs_q  <= pos_q;
      emo_q  <= emo;
      run_q  <= !seen_q || (emo != prev_emo_q);
      last_q <= head_i.eot && last_item;
    end
  end

  assign out_valid_o   = valid_q;
  assign code_point_o  = cp_q;
  assign byte_length_o = len_q;
  assign byte_offset_o = ofs_q;
  assign emoji_o       = emo_q;
  assign run_start_o   = run_q;
  assign last_o        = last_q;

endmodule

// File: rtl/utf8_decode_emoji_run_split_top.sv
`timescale 1ns / 1ps
// channel  | direction | payload
// s_axis   | in        | tdata[7:0] text_byte, tlast end_of_text
// m_axis   | out       | tdata code_point/byte_length/byte_offset, tuser flags, tlast
// cfg      | in        | cfg_data_i[0] emoji_font_present
//
// One byte per cycle is accepted while the request queue has room.
// Results leave at one per cycle while m_axis is ready; a byte causing several
// results holds the back end until all are sent, and the queue absorbs the burst.
// A byte's job is registered in the request queue, and its results again at the output.
// Reset clears decode state, offsets and the emoji font register.
module utf8_decode_emoji_run_split_top #(
  parameter int unsigned FifoDepth = utf8de_pkg::FIFO_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] text_byte
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [55:0] m_axis_tdata_o,   // [20:0] code_point, [23:21] byte_length,
                                        // [55:24] byte_offset
  output logic [1:0]  m_axis_tuser_o,   // [0] emoji flag, [1] run_start
  output logic        m_axis_tlast_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [0:0]  cfg_data_i
);
  import utf8de_pkg::*;

  logic             emoji_font_q;
  logic             full, accept, push, pop, head_valid;
  job_t             job, head;
  logic [CP_W-1:0]  cp;
  logic [LEN_W-1:0] len;
  logic [OFS_W-1:0] ofs;
  logic             emo, run;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = !full;
  assign accept          = s_axis_tvalid_i && !full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      emoji_font_q <= 1'b0;
    end else if (cfg_valid_i) begin
      emoji_font_q <= cfg_data_i[0];
    end
  end

  utf8de_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .byte_i   (s_axis_tdata_i),
    .eot_i    (s_axis_tlast_i),
    .push_o   (push),
    .job_o    (job)
  );

  utf8de_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job),
    .pop_i   (pop),
    .full_o  (full),
    .valid_o (head_valid),
    .job_o   (head)
  );

  utf8de_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .emoji_font_i  (emoji_font_q),
    .head_valid_i  (head_valid),
    .head_i        (head),
    .pop_o         (pop),
    .out_valid_o   (m_axis_tvalid_o),
    .out_ready_i   (m_axis_tready_i),
    .code_point_o  (cp),
    .byte_length_o (len),
    .byte_offset_o (ofs),
    .emoji_o       (emo),
    .run_start_o   (run),
    .last_o        (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {ofs, len, cp};
  assign m_axis_tuser_o = {run, emo};

endmodule
